FILE: rtl/h3fs_pkg.sv
// ----------------------------------------------------------------------------
// h3fs_pkg
// Shared types and constants for the HTTP/3 frame splitter.
// ----------------------------------------------------------------------------
package h3fs_pkg;

    localparam int SLOTS        = 8;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HEADER_BYTES = 16;
    localparam int CNT_W        = $clog2(HEADER_BYTES) + 1;
    localparam int VAL_W        = 62;
    localparam int CTX_W        = 3 * VAL_W;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    localparam logic [0:0] REG_MAX_LEN  = 1'b0;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

FILE: rtl/h3fs_ram.sv
// ----------------------------------------------------------------------------
// h3fs_ram
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module h3fs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/http3_frame_splitter.sv
// ----------------------------------------------------------------------------
// http3_frame_splitter
// Per-stream HTTP/3 frame deframer over QUIC varints.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one stream byte or bare end per transaction,
// tagged with its stream id. Output channel (o_valid/i_ready): one result per
// input transaction, in order. Configuration: APB write of max_payload_length
// at address 0.
// Each transaction passes S_IDLE, which matches the stream against the slot
// table and reads the slot context RAM, then S_EXEC, which updates the
// context, writes it back and loads the output register. A new item is taken
// only in S_IDLE; o_valid rises when S_EXEC loads the output register.
// When the receiver stalls, the finished result holds in the output register,
// the following item waits in the update cycle until that register frees, and
// o_ready stays low meanwhile.
// Reset frees all slots and sets max_payload_length to all ones; the context
// RAM needs no clearing since a new slot's stale context is overwritten before it is used.
// ----------------------------------------------------------------------------
module http3_frame_splitter
    import h3fs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [0:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [VAL_W-1:0] i_stream_number,
    input  logic             i_byte_present,
    input  logic [7:0]       i_data_value,
    input  logic             i_stream_fin,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic             o_payload_valid,
    output logic [7:0]       o_payload_byte,
    output logic [VAL_W-1:0] o_frame_kind,
    output logic             o_frame_end,
    output logic             o_empty_frame,
    output logic             o_stream_closed
);

    t_state r_state, n_state;

    logic [VAL_W-1:0]  r_max;
    logic [SLOTS-1:0]  r_used, r_inf;
    logic [VAL_W-1:0]  r_stream [SLOTS];
    logic [CNT_W-1:0]  r_hc     [SLOTS];
    logic [1:0]        r_tcode  [SLOTS];
    logic [1:0]        r_lcode  [SLOTS];

    logic [SLOT_W-1:0] r_slot;
    logic              r_full, r_new, r_present, r_fin;
    logic [7:0]        r_byte;
    logic [VAL_W-1:0]  r_sid;

    logic              r_ovalid;
    logic [1:0]        r_status;
    logic              r_pvalid, r_fend, r_empty, r_closed;
    logic [7:0]        r_pbyte;
    logic [VAL_W-1:0]  r_kind;

    logic              accept, go;
    logic [SLOT_W-1:0] hit_idx, free_idx, look_idx;
    logic              hit, has_free;
    logic [CTX_W-1:0]  rd_ctx, wr_ctx;

    // slot lookup
    always_comb begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (r_used[k] && r_stream[k] == i_stream_number && !hit) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(k);
            end
            if (!r_used[k] && !has_free) begin
                has_free = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
        look_idx = hit ? hit_idx : free_idx;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_ovalid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready = 1'b0;
        go      = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_EXEC: go = !r_ovalid || i_ready;
            default: begin
                o_ready = 1'b0;
                go      = 1'b0;
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    h3fs_ram #(
        .WIDTH (CTX_W),
        .DEPTH (SLOTS)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (go && !r_full),
        .i_waddr (r_slot),
        .i_wdata (wr_ctx),
        .i_re    (accept),
        .i_raddr (look_idx),
        .o_rdata (rd_ctx)
    );

    // context update
    logic [VAL_W-1:0] c_type, c_total, c_seen, n_type, n_total, n_seen, seen_inc;
    logic [CNT_W-1:0] cnt, n_cnt, n1, tw, lw;
    logic             inf, n_inf, n_used;
    logic [1:0]       tc, lc, n_tc, n_lc;
    logic [1:0]       s_status;
    logic             s_pvalid, s_fend, s_empty, s_closed, skip_fin, done;
    logic [VAL_W-1:0] s_kind;

    always_comb begin
        c_type   = rd_ctx[CTX_W-1 -: VAL_W];
        c_total  = rd_ctx[2*VAL_W-1 -: VAL_W];
        c_seen   = rd_ctx[VAL_W-1:0];
        cnt      = r_new ? '0 : r_hc[r_slot];
        inf      = r_new ? 1'b0 : r_inf[r_slot];
        tc       = r_tcode[r_slot];
        lc       = r_lcode[r_slot];
        n_type   = c_type;
        n_total  = c_total;
        n_seen   = c_seen;
        n_cnt    = cnt;
        n_inf    = inf;
        n_used   = 1'b1;
        n_tc     = tc;
        n_lc     = lc;
        s_status = ST_OK;
        s_pvalid = 1'b0;
        s_fend   = 1'b0;
        s_empty  = 1'b0;
        s_closed = 1'b0;
        s_kind   = '0;
        skip_fin = 1'b0;
        n1       = cnt + CNT_W'(1);
        tw       = '0;
        lw       = '0;
        done     = 1'b0;
        seen_inc = c_seen + VAL_W'(1);
        if (r_full) begin
            s_status = ST_FULL;
        end else begin
            if (r_present) begin
                if (!inf) begin
                    if (cnt == '0) begin
                        n_tc   = r_byte[7:6];
                        n_type = {56'd0, r_byte[5:0]};
                    end else if (cnt < (CNT_W'(1) << tc)) begin
                        n_type = {c_type[VAL_W-9:0], r_byte};
                    end else if (cnt == (CNT_W'(1) << tc)) begin
                        n_lc    = r_byte[7:6];
                        n_total = {56'd0, r_byte[5:0]};
                    end else begin
                        n_total = {c_total[VAL_W-9:0], r_byte};
                    end
                    tw   = CNT_W'(1) << n_tc;
                    lw   = CNT_W'(1) << n_lc;
                    done = (n1 > tw) && (n1 == tw + lw);
                    if (done) begin
                        n_cnt = '0;
                        if (n_total > r_max) begin
                            s_status = ST_TOO_LARGE;
                            skip_fin = 1'b1;
                        end else begin
                            n_seen = '0;
                            n_inf  = 1'b1;
                            if (n_total == '0) begin
                                n_inf   = 1'b0;
                                s_empty = 1'b1;
                                s_fend  = 1'b1;
                                s_kind  = n_type;
                            end
                        end
                    end else begin
                        n_cnt = n1;
                    end
                end else begin
                    s_pvalid = 1'b1;
                    s_kind   = c_type;
                    n_seen   = seen_inc;
                    if (seen_inc >= c_total) begin
                        s_fend = 1'b1;
                        n_inf  = 1'b0;
                    end
                end
            end
            if (r_fin && !skip_fin) begin
                n_used = 1'b0;
                if (n_inf || n_cnt != '0) s_status = ST_TRUNC;
                else s_closed = 1'b1;
                n_inf = 1'b0;
                n_cnt = '0;
            end
        end
        wr_ctx = {n_type, n_total, n_seen};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_max    <= '1;
            r_used   <= '0;
            r_inf    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < SLOTS; k++) r_hc[k] <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == REG_MAX_LEN) begin
                r_max <= pwdata[VAL_W-1:0];
            end
            if (go) begin
                r_ovalid <= 1'b1;
                if (!r_full) begin
                    r_used[r_slot]   <= n_used;
                    r_inf[r_slot]    <= n_inf;
                    r_hc[r_slot]     <= n_cnt;
                    r_tcode[r_slot]  <= n_tc;
                    r_lcode[r_slot]  <= n_lc;
                    if (r_new) r_stream[r_slot] <= r_sid;
                end
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot    <= look_idx;
            r_full    <= !hit && !has_free;
            r_new     <= !hit;
            r_present <= i_byte_present;
            r_fin     <= i_stream_fin;
            r_byte    <= i_data_value;
            r_sid     <= i_stream_number;
        end
        if (go) begin
            r_status <= s_status;
            r_pvalid <= s_pvalid;
            r_pbyte  <= s_pvalid ? r_byte : 8'd0;
            r_kind   <= s_kind;
            r_fend   <= s_fend;
            r_empty  <= s_empty;
            r_closed <= s_closed;
        end
    end

    assign pready          = 1'b1;
    assign prdata          = {2'b00, r_max};
    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_payload_valid = r_pvalid;
    assign o_payload_byte  = r_pbyte;
    assign o_frame_kind    = r_kind;
    assign o_frame_end     = r_fend;
    assign o_empty_frame   = r_empty;
    assign o_stream_closed = r_closed;

endmodule
